/* hw/rtl/cts_pkg.sv */
`timescale 1ns / 1ps
package cts_pkg;

  // Operation codes carried by the mode field of an input transaction.
  localparam logic [1:0] MODE_APPEND = 2'd0;
  localparam logic [1:0] MODE_LATEST = 2'd1;
  localparam logic [1:0] MODE_RANGE  = 2'd2;

  // Status codes of a result transaction.
  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_NONE = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  // Most span results that one range query may produce.
  localparam int unsigned RESULT_CAP = 16;

  // Which source the datapath loads into the output register.
  typedef enum logic [2:0] {
    KIND_APPEND    = 3'd0,
    KIND_NONE      = 3'd1,
    KIND_LATEST    = 3'd2,
    KIND_SPAN      = 3'd3,
    KIND_SPAN_LAST = 3'd4
  } out_kind_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      capture;
    logic      append;
    logic      load_out;
    out_kind_e kind;
    logic      cur_step;
    logic      scan_start;
    logic      scan_run;
    logic      pend_push;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cur_end;
    logic chunk_skip;
    logic chunk_stop;
    logic hit;
    logic abort;
    logic chunk_done;
    logic span_ok;
    logic pend_valid;
    logic cap_full;
    logic out_free;
  } sts_t;

endpackage

/* hw/rtl/cts_ram.sv */
`timescale 1ns / 1ps
module cts_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single port, registered read of the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/cts_ctrl.sv */
`timescale 1ns / 1ps
module cts_ctrl import cts_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] mode_i,
  output logic       in_stall_o,
  input  sts_t       sts_i,
  output cmd_t       cmd_o
);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_APPEND = 8'b0000_0010,
    ST_EMIT   = 8'b0000_0100,
    ST_L_CHK  = 8'b0000_1000,
    ST_L_SCAN = 8'b0001_0000,
    ST_R_CHK  = 8'b0010_0000,
    ST_R_SCAN = 8'b0100_0000,
    ST_R_SPAN = 8'b1000_0000
  } state_e;

  state_e    state_q, state_d;
  out_kind_e kind_q, kind_d;

  // One transaction at a time: input is taken only when the sequencer is idle.
  assign in_stall_o = (state_q != ST_IDLE);

  // Sequencer for append, latest-at and range operations.
  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          unique case (mode_i)
            MODE_APPEND: state_d = ST_APPEND;
            MODE_LATEST: state_d = ST_L_CHK;
            MODE_RANGE:  state_d = ST_R_CHK;
            default: begin
              kind_d  = KIND_NONE;
              state_d = ST_EMIT;
            end
          endcase
        end
      end
      ST_APPEND: begin
        if (sts_i.out_free) begin
          cmd_o.append   = 1'b1;
          cmd_o.load_out = 1'b1;
          cmd_o.kind     = KIND_APPEND;
          state_d        = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.kind     = kind_q;
          state_d        = ST_IDLE;
        end
      end
      ST_L_CHK: begin
        if (sts_i.cur_end) begin
          kind_d  = KIND_NONE;
          state_d = ST_EMIT;
        end else if (sts_i.chunk_skip) begin
          cmd_o.cur_step = 1'b1;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d          = ST_L_SCAN;
        end
      end
      ST_L_SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (sts_i.hit) begin
          kind_d  = KIND_LATEST;
          state_d = ST_EMIT;
        end else if (sts_i.chunk_done) begin
          cmd_o.cur_step = 1'b1;
          state_d        = ST_L_CHK;
        end
      end
      ST_R_CHK: begin
        if (sts_i.cur_end) begin
          kind_d  = sts_i.pend_valid ? KIND_SPAN_LAST : KIND_NONE;
          state_d = ST_EMIT;
        end else if (sts_i.chunk_skip) begin
          cmd_o.cur_step = 1'b1;
        end else if (sts_i.chunk_stop) begin
          kind_d  = sts_i.pend_valid ? KIND_SPAN_LAST : KIND_NONE;
          state_d = ST_EMIT;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d          = ST_R_SCAN;
        end
      end
      ST_R_SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (sts_i.abort) begin
          kind_d  = KIND_NONE;
          state_d = ST_EMIT;
        end else if (sts_i.chunk_done) begin
          if (sts_i.span_ok) begin
            state_d = ST_R_SPAN;
          end else begin
            cmd_o.cur_step = 1'b1;
            state_d        = ST_R_CHK;
          end
        end
      end
      ST_R_SPAN: begin
        // The held span goes out once a newer span proves it is not the final one.
        if (sts_i.cap_full) begin
          cmd_o.cur_step = 1'b1;
          state_d        = ST_R_CHK;
        end else if (!sts_i.pend_valid) begin
          cmd_o.pend_push = 1'b1;
          cmd_o.cur_step  = 1'b1;
          state_d         = ST_R_CHK;
        end else if (sts_i.out_free) begin
          cmd_o.load_out  = 1'b1;
          cmd_o.kind      = KIND_SPAN;
          cmd_o.pend_push = 1'b1;
          cmd_o.cur_step  = 1'b1;
          state_d         = ST_R_CHK;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kind_q  <= KIND_NONE;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

endmodule

/* hw/rtl/cts_datapath.sv */
`timescale 1ns / 1ps
module cts_datapath import cts_pkg::*; #(
  parameter int unsigned MAX_CHUNKS     = 16,
  parameter int unsigned ROWS_PER_CHUNK = 256,
  localparam int unsigned RIW       = (ROWS_PER_CHUNK > 1) ? $clog2(ROWS_PER_CHUNK) : 1,
  localparam int unsigned MEM_DEPTH = MAX_CHUNKS * (2 ** RIW),
  localparam int unsigned MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [1:0]         mode_i,
  input  logic               new_chunk_i,
  input  logic signed [63:0] sample_time_i,
  input  logic signed [63:0] query_time_i,
  input  logic signed [63:0] range_low_i,
  input  logic signed [63:0] range_high_i,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  output logic               mem_we_o,
  output logic [MEM_AW-1:0]  mem_addr_o,
  output logic [63:0]        mem_wdata_o,
  input  logic [63:0]        mem_rdata_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output logic [1:0]         status_o,
  output logic [3:0]         chunk_number_o,
  output logic [7:0]         row_first_o,
  output logic [8:0]         row_end_o,
  output logic signed [63:0] found_time_o,
  output logic               last_o
);

  localparam int unsigned CIW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int unsigned CUW = $clog2(MAX_CHUNKS + 1);
  localparam int unsigned RCW = $clog2(ROWS_PER_CHUNK + 1);
  localparam int unsigned NW  = $clog2(RESULT_CAP + 1);

  // Captured transaction.
  logic [1:0]         mode_q;
  logic               new_chunk_q;
  logic signed [63:0] sample_q, query_q, lo_q, hi_q;

  // Chunk headers.
  logic [CUW-1:0]     used_q;
  logic [RCW-1:0]     rows_q [MAX_CHUNKS];
  logic signed [63:0] min_q  [MAX_CHUNKS];
  logic signed [63:0] max_q  [MAX_CHUNKS];

  // Scan state.
  logic [CUW-1:0] cur_q;
  logic [RCW-1:0] iss_q;
  logic           dv_q, dv_d;
  logic [RIW-1:0] drow_q;
  logic           in_span_q, located_q;
  logic [RIW-1:0] first_q;

  // Latest-at hit.
  logic [CIW-1:0]     fnd_chunk_q;
  logic [RIW-1:0]     fnd_row_q;
  logic signed [63:0] fnd_time_q;

  // Span just closed, and span held back until the next one shows up.
  logic [CIW-1:0] new_chunk_idx_q;
  logic [RIW-1:0] new_first_q;
  logic [RCW-1:0] new_end_q;
  logic           pend_valid_q;
  logic [CIW-1:0] pend_chunk_q;
  logic [RIW-1:0] pend_first_q;
  logic [RCW-1:0] pend_end_q;
  logic [NW-1:0]  n_q;

  // Output register.
  logic               out_valid_q;
  logic [1:0]         out_status_q, out_status_d;
  logic [3:0]         out_chunk_q, out_chunk_d;
  logic [7:0]         out_first_q, out_first_d;
  logic [8:0]         out_end_q, out_end_d;
  logic signed [63:0] out_time_q, out_time_d;
  logic               out_last_q, out_last_d;

  // Header lookup and append decision.
  logic               is_latest, is_append;
  logic [CUW-1:0]     used_m1, cur_m1;
  logic [CIW-1:0]     sel_idx, chunk_idx;
  logic [RCW-1:0]     rows_sel;
  logic signed [63:0] min_sel, max_sel;
  logic               need_new, store_full, app_write;
  logic [CIW-1:0]     app_chunk;
  logic [RCW-1:0]     app_row;
  logic signed [63:0] app_min, app_max;

  assign is_latest = (mode_q == MODE_LATEST);
  assign is_append = (mode_q == MODE_APPEND);
  assign used_m1   = used_q - CUW'(1);
  assign cur_m1    = cur_q - CUW'(1);
  assign sel_idx   = is_latest ? cur_m1[CIW-1:0] : cur_q[CIW-1:0];
  assign chunk_idx = is_append ? used_m1[CIW-1:0] : sel_idx;
  assign rows_sel  = rows_q[chunk_idx];
  assign min_sel   = min_q[chunk_idx];
  assign max_sel   = max_q[chunk_idx];

  assign need_new   = (used_q == '0) || new_chunk_q || (rows_sel >= RCW'(ROWS_PER_CHUNK));
  assign store_full = need_new && (used_q >= CUW'(MAX_CHUNKS));
  assign app_write  = cmd_i.append && !store_full;
  assign app_chunk  = need_new ? used_q[CIW-1:0] : used_m1[CIW-1:0];
  assign app_row    = need_new ? '0 : rows_sel;
  assign app_min    = (need_new || (sample_q < min_sel)) ? sample_q : min_sel;
  assign app_max    = (need_new || (sample_q > max_sel)) ? sample_q : max_sel;

  // Row scan: one read issued per cycle, compare on the data of the previous read.
  logic signed [63:0] ts;
  logic               can_issue;
  logic [RCW-1:0]     issue_row;
  logic               ge_lo, le_hi, le_t;
  logic               l_hit, l_done;
  logic               seek, r_begin, r_abort, r_empty, r_close, r_exhaust, r_done, r_span;
  logic               ev_end;

  assign ts        = $signed(mem_rdata_i);
  assign can_issue = is_latest ? (iss_q != '0) : (iss_q < rows_sel);
  assign issue_row = is_latest ? (iss_q - RCW'(1)) : iss_q;
  assign ge_lo     = (ts >= lo_q);
  assign le_hi     = (ts <= hi_q);
  assign le_t      = (ts <= query_q);

  assign l_hit  = dv_q && le_t;
  assign l_done = !dv_q && (iss_q == '0);

  assign seek      = dv_q && !in_span_q && ge_lo;
  assign r_begin   = seek && le_hi;
  assign r_abort   = seek && !le_hi && !located_q;
  assign r_empty   = seek && !le_hi && located_q;
  assign r_close   = dv_q && in_span_q && !le_hi;
  assign r_exhaust = !dv_q && (iss_q == rows_sel);
  assign r_done    = r_empty || r_close || r_exhaust;
  assign r_span    = r_close || (r_exhaust && in_span_q);

  assign ev_end = is_latest ? (l_hit || l_done) : (r_abort || r_done);
  assign dv_d   = cmd_i.scan_run && can_issue && !ev_end;

  // Memory port shared by the append write and the scan reads.
  assign mem_we_o    = app_write;
  assign mem_wdata_o = sample_q;
  assign mem_addr_o  = is_append ? MEM_AW'({app_chunk, app_row[RIW-1:0]})
                                 : MEM_AW'({sel_idx, issue_row[RIW-1:0]});

  // Status toward the controller.
  logic out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    sts_o            = '0;
    sts_o.cur_end    = is_latest ? (cur_q == '0) : (cur_q == used_q);
    sts_o.chunk_skip = is_latest ? (min_sel > query_q) : (max_sel < lo_q);
    sts_o.chunk_stop = !is_latest && located_q && (min_sel > hi_q);
    sts_o.hit        = is_latest && l_hit;
    sts_o.abort      = !is_latest && r_abort;
    sts_o.chunk_done = is_latest ? l_done : r_done;
    sts_o.span_ok    = r_span;
    sts_o.pend_valid = pend_valid_q;
    sts_o.cap_full   = (n_q == NW'(RESULT_CAP));
    sts_o.out_free   = out_free;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q       <= '0;
      cur_q        <= '0;
      iss_q        <= '0;
      dv_q         <= 1'b0;
      in_span_q    <= 1'b0;
      located_q    <= 1'b0;
      pend_valid_q <= 1'b0;
      n_q          <= '0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < MAX_CHUNKS; i++) begin
        rows_q[i] <= '0;
      end
    end else begin
      dv_q <= dv_d;
      if (cmd_i.capture) begin
        cur_q        <= (mode_i == MODE_LATEST) ? used_q : '0;
        located_q    <= 1'b0;
        pend_valid_q <= 1'b0;
        n_q          <= '0;
      end
      if (app_write) begin
        rows_q[app_chunk] <= app_row + RCW'(1);
        if (need_new) begin
          used_q <= used_q + CUW'(1);
        end
      end
      if (cmd_i.cur_step) begin
        cur_q <= is_latest ? cur_m1 : (cur_q + CUW'(1));
      end
      if (cmd_i.scan_start) begin
        iss_q     <= is_latest ? rows_sel : '0;
        in_span_q <= 1'b0;
      end
      if (cmd_i.scan_run) begin
        if (can_issue) begin
          iss_q <= is_latest ? (iss_q - RCW'(1)) : (iss_q + RCW'(1));
        end
        if (!is_latest && r_begin) begin
          in_span_q <= 1'b1;
          located_q <= 1'b1;
        end
      end
      if (cmd_i.pend_push) begin
        pend_valid_q <= 1'b1;
        n_q          <= n_q + NW'(1);
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    drow_q <= issue_row[RIW-1:0];
    if (cmd_i.capture) begin
      mode_q      <= mode_i;
      new_chunk_q <= new_chunk_i;
      sample_q    <= sample_time_i;
      query_q     <= query_time_i;
      lo_q        <= range_low_i;
      hi_q        <= range_high_i;
    end
    if (app_write) begin
      min_q[app_chunk] <= app_min;
      max_q[app_chunk] <= app_max;
    end
    if (cmd_i.scan_run && !is_latest && r_begin) begin
      first_q <= drow_q;
    end
    if (cmd_i.scan_run && is_latest && l_hit) begin
      fnd_chunk_q <= sel_idx;
      fnd_row_q   <= drow_q;
      fnd_time_q  <= ts;
    end
    if (cmd_i.scan_run && !is_latest && r_span) begin
      new_chunk_idx_q <= sel_idx;
      new_first_q     <= first_q;
      new_end_q       <= r_close ? RCW'(drow_q) : rows_sel;
    end
    if (cmd_i.pend_push) begin
      pend_chunk_q <= new_chunk_idx_q;
      pend_first_q <= new_first_q;
      pend_end_q   <= new_end_q;
    end
    if (cmd_i.load_out) begin
      out_status_q <= out_status_d;
      out_chunk_q  <= out_chunk_d;
      out_first_q  <= out_first_d;
      out_end_q    <= out_end_d;
      out_time_q   <= out_time_d;
      out_last_q   <= out_last_d;
    end
  end

  // Result assembly; index fields are cut to the widths of the output fields.
  logic [CIW-1:0] res_chunk;
  logic [RIW-1:0] res_first;
  logic [RCW-1:0] res_end;
  logic [31:0]    chunk_w, first_w, end_w;

  always_comb begin
    out_status_d = STATUS_NONE;
    res_chunk    = '0;
    res_first    = '0;
    res_end      = '0;
    out_time_d   = '0;
    out_last_d   = 1'b1;
    case (cmd_i.kind)
      KIND_APPEND: begin
        if (store_full) begin
          out_status_d = STATUS_FULL;
        end else begin
          out_status_d = STATUS_OK;
          res_chunk    = app_chunk;
          res_first    = app_row[RIW-1:0];
          res_end      = app_row + RCW'(1);
        end
      end
      KIND_LATEST: begin
        out_status_d = STATUS_OK;
        res_chunk    = fnd_chunk_q;
        res_first    = fnd_row_q;
        res_end      = RCW'(fnd_row_q) + RCW'(1);
        out_time_d   = fnd_time_q;
      end
      KIND_SPAN, KIND_SPAN_LAST: begin
        out_status_d = STATUS_OK;
        res_chunk    = pend_chunk_q;
        res_first    = pend_first_q;
        res_end      = pend_end_q;
        out_last_d   = (cmd_i.kind == KIND_SPAN_LAST);
      end
      default: begin
        out_status_d = STATUS_NONE;
      end
    endcase
  end

  assign chunk_w     = 32'(res_chunk);
  assign first_w     = 32'(res_first);
  assign end_w       = 32'(res_end);
  assign out_chunk_d = chunk_w[3:0];
  assign out_first_d = first_w[7:0];
  assign out_end_d   = end_w[8:0];

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign chunk_number_o = out_chunk_q;
  assign row_first_o    = out_first_q;
  assign row_end_o      = out_end_q;
  assign found_time_o   = out_time_q;
  assign last_o         = out_last_q;

endmodule

/* hw/rtl/chunked_timestamp_query.sv */
`timescale 1ns / 1ps
// Chunked timestamp store with append, latest-at and range queries. Samples are appended
// into up to MAX_CHUNKS chunks of up to ROWS_PER_CHUNK rows, and each chunk keeps its row
// count, minimum and maximum time. A latest-at query returns the last row at or below the
// query time; a range query returns one row span per overlapping chunk, with last set on
// the final one; a query without a match returns one not-found result. The block takes
// one transaction at a time. A query checks each chunk header and skips the chunks that
// cannot match; in a chunk it scans, the rows stream out of the single-port time memory
// one per cycle behind a registered read. The block also waits whenever a result must
// enter the output register while the result already there is stalled. A finished
// result sits in an output register, so the next transaction can be accepted while it
// waits to be taken.
module chunked_timestamp_query import cts_pkg::*; #(
  parameter int unsigned MAX_CHUNKS     = 16,
  parameter int unsigned ROWS_PER_CHUNK = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         mode_i,
  input  logic               new_chunk_i,
  input  logic signed [63:0] sample_time_i,
  input  logic signed [63:0] query_time_i,
  input  logic signed [63:0] range_low_i,
  input  logic signed [63:0] range_high_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic [3:0]         chunk_number_o,
  output logic [7:0]         row_first_o,
  output logic [8:0]         row_end_o,
  output logic signed [63:0] found_time_o,
  output logic               last_o
);

  localparam int unsigned RIW       = (ROWS_PER_CHUNK > 1) ? $clog2(ROWS_PER_CHUNK) : 1;
  localparam int unsigned MEM_DEPTH = MAX_CHUNKS * (2 ** RIW);
  localparam int unsigned MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  cmd_t              cmd;
  sts_t              sts;
  logic              mem_we;
  logic [MEM_AW-1:0] mem_addr;
  logic [63:0]       mem_wdata, mem_rdata;

  // Sequencer.
  cts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mode_i     (mode_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Chunk headers, row scan and output register.
  cts_datapath #(
    .MAX_CHUNKS     (MAX_CHUNKS),
    .ROWS_PER_CHUNK (ROWS_PER_CHUNK)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .mode_i         (mode_i),
    .new_chunk_i    (new_chunk_i),
    .sample_time_i  (sample_time_i),
    .query_time_i   (query_time_i),
    .range_low_i    (range_low_i),
    .range_high_i   (range_high_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .mem_we_o       (mem_we),
    .mem_addr_o     (mem_addr),
    .mem_wdata_o    (mem_wdata),
    .mem_rdata_i    (mem_rdata),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .status_o       (status_o),
    .chunk_number_o (chunk_number_o),
    .row_first_o    (row_first_o),
    .row_end_o      (row_end_o),
    .found_time_o   (found_time_o),
    .last_o         (last_o)
  );

  // Row timestamps, addressed by chunk and row.
  cts_ram #(
    .WIDTH (64),
    .DEPTH (MEM_DEPTH)
  ) u_time_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

endmodule

/* hw/rtl/cts_checker.sv */
`timescale 1ns / 1ps
module cts_checker import cts_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [1:0]         status_o,
  input logic [3:0]         chunk_number_o,
  input logic [7:0]         row_first_o,
  input logic [8:0]         row_end_o,
  input logic signed [63:0] found_time_o,
  input logic               last_o
);

  // A stalled result transaction holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
      $stable(chunk_number_o) && $stable(row_first_o) && $stable(row_end_o) &&
      $stable(found_time_o) && $stable(last_o))
    else $error("result changed while stalled");

  // The block works on one input transaction at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted while previous transaction in progress");

  // A rejected append carries no row information and ends its transaction.
  a_full_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STATUS_FULL) |-> last_o && (chunk_number_o == '0) &&
      (row_first_o == '0) && (row_end_o == '0) && (found_time_o == '0))
    else $error("store-full result with nonzero fields");

  // A not-found result is always the single, final result.
  a_none_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STATUS_NONE) |-> last_o && (chunk_number_o == '0) &&
      (row_first_o == '0) && (row_end_o == '0) && (found_time_o == '0))
    else $error("not-found result with nonzero fields");

  // Spans before the final result of a range query carry no time.
  a_span_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STATUS_OK) && !last_o |-> (found_time_o == '0))
    else $error("intermediate span carries a timestamp");

endmodule

bind chunked_timestamp_query cts_checker u_checker (.*);
